FILE: design/modular_arithmetic_unit_defines.svh
// Assertion macros for the modular arithmetic unit.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset
`define MAU_CHECK(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("modular_arithmetic_unit: check failed");
// Check that a trigger implies a consequence in the next cycle
`define MAU_CHECK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modular_arithmetic_unit: sequence check failed");
`else
`define MAU_CHECK(label, clk, rst_n, cond)
`define MAU_CHECK_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/mau_pkg.sv
// Shared types and constants of the modular arithmetic unit.
// Used by the controller, the datapath and the top level; no dependencies.
package mau_pkg;

    localparam int ResBits = 30;
    localparam int ExpBits = 63;
    localparam int RawBits = 64;
    localparam int ProdBits = 2 * ResBits;
    localparam int RedLen = RawBits;
    localparam int CntBits = $clog2(RedLen + 1);
    localparam logic [ResBits-1:0] ModReset = ResBits'(998244353);

    typedef enum logic [2:0] {
        OP_REDUCE  = 3'd0,
        OP_ADD     = 3'd1,
        OP_SUB     = 3'd2,
        OP_MUL     = 3'd3,
        OP_DIV     = 3'd4,
        OP_POW     = 3'd5,
        OP_INVERSE = 3'd6,
        OP_NEGATE  = 3'd7
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RAW_WAIT,
        ST_A_WAIT,
        ST_B_START,
        ST_B_WAIT,
        ST_DISPATCH,
        ST_MUL_WAIT,
        ST_POW_TEST,
        ST_ACC_WAIT,
        ST_SQ_START,
        ST_SQ_WAIT,
        ST_FIN_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_RED_RAW,
        DP_RAW_FIX,
        DP_RED_A,
        DP_WB_A,
        DP_RED_B,
        DP_WB_B,
        DP_ADD,
        DP_SUB,
        DP_NEG,
        DP_ZERO,
        DP_MUL_AB,
        DP_WB_RES,
        DP_POW_INIT,
        DP_INV_INIT_A,
        DP_INV_INIT_B,
        DP_MUL_ACC,
        DP_WB_ACC,
        DP_MUL_SQ,
        DP_WB_SQ,
        DP_MUL_ACC_A,
        DP_RES_ACC,
        DP_PUSH
    } t_dp_cmd;

    typedef struct packed {
        t_dp_cmd cmd;
    } t_ctrl_cmd;

    typedef struct packed {
        logic busy;
        logic e_zero;
        logic e_lsb;
        logic a_zero;
        logic b_zero;
        logic mod_small;
        t_op  op;
    } t_dp_status;

endpackage

FILE: design/mau_ctrl.sv
// Controller state machine of the modular arithmetic unit.
// Sequences datapath commands per operation; depends on mau_pkg.
module mau_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_cfg_ready,
    input  mau_pkg::t_dp_status  i_status,
    output mau_pkg::t_ctrl_cmd   o_cmd
);

    mau_pkg::t_state r_state;
    mau_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    // Output register can take a result when empty or being drained
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_in_stall  = (r_state != mau_pkg::ST_IDLE);
    assign o_cfg_ready = (r_state == mau_pkg::ST_IDLE);

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mau_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_cmd.cmd   = mau_pkg::DP_NOP;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            mau_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cmd = mau_pkg::DP_LOAD;
                    n_state   = mau_pkg::ST_CHECK;
                end
            end
            mau_pkg::ST_CHECK: begin
                if (i_status.mod_small) begin
                    o_cmd.cmd = mau_pkg::DP_ZERO;
                    n_state   = mau_pkg::ST_DONE;
                end else if (i_status.op == mau_pkg::OP_REDUCE) begin
                    o_cmd.cmd = mau_pkg::DP_RED_RAW;
                    n_state   = mau_pkg::ST_RAW_WAIT;
                end else begin
                    o_cmd.cmd = mau_pkg::DP_RED_A;
                    n_state   = mau_pkg::ST_A_WAIT;
                end
            end
            mau_pkg::ST_RAW_WAIT: begin
                if (!i_status.busy) begin
                    o_cmd.cmd = mau_pkg::DP_RAW_FIX;
                    n_state   = mau_pkg::ST_DONE;
                end
            end
            mau_pkg::ST_A_WAIT: begin
                if (!i_status.busy) begin
                    o_cmd.cmd = mau_pkg::DP_WB_A;
                    n_state   = mau_pkg::ST_B_START;
                end
            end
            mau_pkg::ST_B_START: begin
                o_cmd.cmd = mau_pkg::DP_RED_B;
                n_state   = mau_pkg::ST_B_WAIT;
            end
            mau_pkg::ST_B_WAIT: begin
                if (!i_status.busy) begin
                    o_cmd.cmd = mau_pkg::DP_WB_B;
                    n_state   = mau_pkg::ST_DISPATCH;
                end
            end
            mau_pkg::ST_DISPATCH: begin
                n_state = mau_pkg::ST_DONE;
                case (i_status.op)
                    mau_pkg::OP_ADD:    o_cmd.cmd = mau_pkg::DP_ADD;
                    mau_pkg::OP_SUB:    o_cmd.cmd = mau_pkg::DP_SUB;
                    mau_pkg::OP_NEGATE: o_cmd.cmd = mau_pkg::DP_NEG;
                    mau_pkg::OP_MUL: begin
                        o_cmd.cmd = mau_pkg::DP_MUL_AB;
                        n_state   = mau_pkg::ST_MUL_WAIT;
                    end
                    mau_pkg::OP_POW: begin
                        o_cmd.cmd = mau_pkg::DP_POW_INIT;
                        n_state   = mau_pkg::ST_POW_TEST;
                    end
                    mau_pkg::OP_INVERSE: begin
                        if (i_status.a_zero) begin
                            o_cmd.cmd = mau_pkg::DP_ZERO;
                        end else begin
                            o_cmd.cmd = mau_pkg::DP_INV_INIT_A;
                            n_state   = mau_pkg::ST_POW_TEST;
                        end
                    end
                    mau_pkg::OP_DIV: begin
                        if (i_status.b_zero) begin
                            o_cmd.cmd = mau_pkg::DP_ZERO;
                        end else begin
                            o_cmd.cmd = mau_pkg::DP_INV_INIT_B;
                            n_state   = mau_pkg::ST_POW_TEST;
                        end
                    end
                    default: o_cmd.cmd = mau_pkg::DP_ZERO;
                endcase
            end
            mau_pkg::ST_MUL_WAIT: begin
                if (!i_status.busy) begin
                    o_cmd.cmd = mau_pkg::DP_WB_RES;
                    n_state   = mau_pkg::ST_DONE;
                end
            end
            mau_pkg::ST_POW_TEST: begin
                if (i_status.e_zero) begin
                    if (i_status.op == mau_pkg::OP_DIV) begin
                        o_cmd.cmd = mau_pkg::DP_MUL_ACC_A;
                        n_state   = mau_pkg::ST_FIN_WAIT;
                    end else begin
                        o_cmd.cmd = mau_pkg::DP_RES_ACC;
                        n_state   = mau_pkg::ST_DONE;
                    end
                end else if (i_status.e_lsb) begin
                    o_cmd.cmd = mau_pkg::DP_MUL_ACC;
                    n_state   = mau_pkg::ST_ACC_WAIT;
                end else begin
                    o_cmd.cmd = mau_pkg::DP_MUL_SQ;
                    n_state   = mau_pkg::ST_SQ_WAIT;
                end
            end
            mau_pkg::ST_ACC_WAIT: begin
                if (!i_status.busy) begin
                    o_cmd.cmd = mau_pkg::DP_WB_ACC;
                    n_state   = mau_pkg::ST_SQ_START;
                end
            end
            mau_pkg::ST_SQ_START: begin
                o_cmd.cmd = mau_pkg::DP_MUL_SQ;
                n_state   = mau_pkg::ST_SQ_WAIT;
            end
            mau_pkg::ST_SQ_WAIT: begin
                if (!i_status.busy) begin
                    o_cmd.cmd = mau_pkg::DP_WB_SQ;
                    n_state   = mau_pkg::ST_POW_TEST;
                end
            end
            mau_pkg::ST_FIN_WAIT: begin
                if (!i_status.busy) begin
                    o_cmd.cmd = mau_pkg::DP_WB_RES;
                    n_state   = mau_pkg::ST_DONE;
                end
            end
            mau_pkg::ST_DONE: begin
                // Move the result into the output register once it is free
                if (out_free) begin
                    o_cmd.cmd   = mau_pkg::DP_PUSH;
                    n_out_valid = 1'b1;
                    n_state     = mau_pkg::ST_IDLE;
                end
            end
            default: n_state = mau_pkg::ST_IDLE;
        endcase
    end

endmodule

FILE: design/mau_datapath.sv
// Datapath of the modular arithmetic unit: operand and power registers,
// one 30x30 multiplier and a bit-serial remainder unit; depends on mau_pkg.
module mau_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [mau_pkg::ResBits-1:0]   i_cfg_modulus,
    input  logic [2:0]                    i_op,
    input  logic [mau_pkg::ResBits-1:0]   i_operand_a,
    input  logic [mau_pkg::ResBits-1:0]   i_operand_b,
    input  logic [mau_pkg::ExpBits-1:0]   i_exponent,
    input  logic signed [mau_pkg::RawBits-1:0] i_raw_integer,
    input  mau_pkg::t_ctrl_cmd            i_cmd,
    output mau_pkg::t_dp_status           o_status,
    output logic [mau_pkg::ResBits-1:0]   o_result_value
);

    logic [mau_pkg::ResBits-1:0]  r_mod;
    mau_pkg::t_op                 r_op;
    logic [mau_pkg::ResBits-1:0]  r_a;
    logic [mau_pkg::ResBits-1:0]  r_b;
    logic [mau_pkg::ResBits-1:0]  r_acc;
    logic [mau_pkg::ResBits-1:0]  r_sq;
    logic [mau_pkg::ExpBits-1:0]  r_exp;
    logic [mau_pkg::RawBits-1:0]  r_raw;
    logic [mau_pkg::ResBits-1:0]  r_res;
    logic [mau_pkg::ResBits-1:0]  r_out;
    logic [mau_pkg::RawBits-1:0]  r_x;
    logic [mau_pkg::ResBits-1:0]  r_rem;
    logic [mau_pkg::CntBits-1:0]  r_cnt;

    logic [mau_pkg::ResBits:0]    shifted;
    logic [mau_pkg::ResBits:0]    mod_ext;
    logic [mau_pkg::ResBits-1:0]  n_rem;
    logic [mau_pkg::ResBits-1:0]  mul_x;
    logic [mau_pkg::ResBits-1:0]  mul_y;
    logic [mau_pkg::ProdBits-1:0] prod;
    logic [mau_pkg::RawBits-1:0]  raw_mag;
    logic [mau_pkg::ResBits:0]    sum;
    logic [mau_pkg::ResBits-1:0]  add_res;
    logic [mau_pkg::ResBits-1:0]  sub_res;
    logic [mau_pkg::ResBits-1:0]  neg_res;
    logic [mau_pkg::ResBits-1:0]  raw_res;
    logic                         start;

    // One restoring remainder step: shift in the next dividend bit
    assign mod_ext = {1'b0, r_mod};
    assign shifted = {r_rem, r_x[mau_pkg::RawBits-1]};
    always_comb begin
        if (shifted >= mod_ext) begin
            n_rem = mau_pkg::ResBits'(shifted - mod_ext);
        end else begin
            n_rem = shifted[mau_pkg::ResBits-1:0];
        end
    end

    // Select multiplier operands
    always_comb begin
        mul_x = r_a;
        mul_y = r_b;
        case (i_cmd.cmd)
            mau_pkg::DP_MUL_ACC: begin
                mul_x = r_acc;
                mul_y = r_sq;
            end
            mau_pkg::DP_MUL_SQ: begin
                mul_x = r_sq;
                mul_y = r_sq;
            end
            mau_pkg::DP_MUL_ACC_A: begin
                mul_x = r_acc;
                mul_y = r_a;
            end
            default: begin
                mul_x = r_a;
                mul_y = r_b;
            end
        endcase
    end
    assign prod = mul_x * mul_y;

    // Magnitude of the signed integer for reduce
    assign raw_mag = r_raw[mau_pkg::RawBits-1] ? (~r_raw + 1'b1) : r_raw;

    // Combinational residue operations on reduced operands and the sign fix for reduce
    assign sum     = {1'b0, r_a} + {1'b0, r_b};
    assign add_res = (sum >= mod_ext) ? mau_pkg::ResBits'(sum - mod_ext)
                                      : sum[mau_pkg::ResBits-1:0];
    assign sub_res = (r_a >= r_b) ? (r_a - r_b) : (r_mod - (r_b - r_a));
    assign neg_res = (r_a == '0) ? '0 : (r_mod - r_a);
    assign raw_res = (r_raw[mau_pkg::RawBits-1] && (r_rem != '0)) ? (r_mod - r_rem) : r_rem;

    assign start = (i_cmd.cmd == mau_pkg::DP_RED_RAW) || (i_cmd.cmd == mau_pkg::DP_RED_A) ||
                   (i_cmd.cmd == mau_pkg::DP_RED_B) || (i_cmd.cmd == mau_pkg::DP_MUL_AB) ||
                   (i_cmd.cmd == mau_pkg::DP_MUL_ACC) || (i_cmd.cmd == mau_pkg::DP_MUL_SQ) ||
                   (i_cmd.cmd == mau_pkg::DP_MUL_ACC_A);

    // Modulus register and remainder counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= mau_pkg::ModReset;
            r_cnt <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                r_mod <= i_cfg_modulus;
            end
            if (start) begin
                r_cnt <= mau_pkg::CntBits'(mau_pkg::RedLen);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Payload registers: advance the remainder unit and apply commands
    always_ff @(posedge i_clk) begin
        if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_x   <= {r_x[mau_pkg::RawBits-2:0], 1'b0};
        end
        case (i_cmd.cmd)
            mau_pkg::DP_LOAD: begin
                r_op  <= mau_pkg::t_op'(i_op);
                r_a   <= i_operand_a;
                r_b   <= i_operand_b;
                r_exp <= i_exponent;
                r_raw <= i_raw_integer;
            end
            mau_pkg::DP_RED_RAW: begin
                r_x   <= raw_mag;
                r_rem <= '0;
            end
            mau_pkg::DP_RED_A: begin
                r_x   <= mau_pkg::RawBits'(r_a);
                r_rem <= '0;
            end
            mau_pkg::DP_RED_B: begin
                r_x   <= mau_pkg::RawBits'(r_b);
                r_rem <= '0;
            end
            mau_pkg::DP_MUL_AB, mau_pkg::DP_MUL_ACC, mau_pkg::DP_MUL_SQ,
            mau_pkg::DP_MUL_ACC_A: begin
                r_x   <= mau_pkg::RawBits'(prod);
                r_rem <= '0;
            end
            mau_pkg::DP_RAW_FIX:  r_res <= raw_res;
            mau_pkg::DP_WB_A:     r_a   <= r_rem;
            mau_pkg::DP_WB_B:     r_b   <= r_rem;
            mau_pkg::DP_ADD:      r_res <= add_res;
            mau_pkg::DP_SUB:      r_res <= sub_res;
            mau_pkg::DP_NEG:      r_res <= neg_res;
            mau_pkg::DP_ZERO:     r_res <= '0;
            mau_pkg::DP_WB_RES:   r_res <= r_rem;
            mau_pkg::DP_POW_INIT: begin
                r_acc <= mau_pkg::ResBits'(1);
                r_sq  <= r_a;
            end
            mau_pkg::DP_INV_INIT_A: begin
                r_acc <= mau_pkg::ResBits'(1);
                r_sq  <= r_a;
                r_exp <= mau_pkg::ExpBits'(r_mod - mau_pkg::ResBits'(2));
            end
            mau_pkg::DP_INV_INIT_B: begin
                r_acc <= mau_pkg::ResBits'(1);
                r_sq  <= r_b;
                r_exp <= mau_pkg::ExpBits'(r_mod - mau_pkg::ResBits'(2));
            end
            mau_pkg::DP_WB_ACC:   r_acc <= r_rem;
            mau_pkg::DP_WB_SQ: begin
                r_sq  <= r_rem;
                r_exp <= r_exp >> 1;
            end
            mau_pkg::DP_RES_ACC:  r_res <= r_acc;
            mau_pkg::DP_PUSH:     r_out <= r_res;
            default: ;
        endcase
    end

    // Status toward the controller
    assign o_status.busy      = (r_cnt != '0);
    assign o_status.e_zero    = (r_exp == '0);
    assign o_status.e_lsb     = r_exp[0];
    assign o_status.a_zero    = (r_a == '0);
    assign o_status.b_zero    = (r_b == '0);
    assign o_status.mod_small = (r_mod[mau_pkg::ResBits-1:1] == '0);
    assign o_status.op        = r_op;

    assign o_result_value = r_out;

endmodule

FILE: design/modular_arithmetic_unit.sv
// Modular arithmetic unit: reduce, add, sub, mul, div, pow, inverse, negate.
// Every modular reduction shifts all 64 dividend bits through the bit-serial remainder unit.
// One transaction at a time; a finished result waits in the output register.
// Reset (synchronous, active low) clears control and sets modulus 998244353.
`include "modular_arithmetic_unit_defines.svh"

module modular_arithmetic_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mau_pkg::ResBits-1:0]       i_cfg_modulus,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [2:0]                        i_op,
    input  logic [mau_pkg::ResBits-1:0]       i_operand_a,
    input  logic [mau_pkg::ResBits-1:0]       i_operand_b,
    input  logic [mau_pkg::ExpBits-1:0]       i_exponent,
    input  logic signed [mau_pkg::RawBits-1:0] i_raw_integer,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mau_pkg::ResBits-1:0]       o_result_value
);

    mau_pkg::t_ctrl_cmd  cmd;
    mau_pkg::t_dp_status status;

    // Sequence the operation
    mau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cfg_ready (o_cfg_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Compute on residues
    mau_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_modulus  (i_cfg_modulus),
        .i_op           (i_op),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_exponent     (i_exponent),
        .i_raw_integer  (i_raw_integer),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_result_value (o_result_value)
    );

    // A new transaction is never taken while the remainder unit runs
    `MAU_CHECK(a_idle_reducer, i_clk, i_rst_n, !o_in_stall |-> !status.busy)
    // An accepted transaction stalls the input on the next cycle
    `MAU_CHECK_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // A squaring or accumulate multiply command sets the remainder unit busy
    `MAU_CHECK_NEXT(a_start_idle, i_clk, i_rst_n,
        cmd.cmd == mau_pkg::DP_MUL_SQ || cmd.cmd == mau_pkg::DP_MUL_ACC, status.busy)

endmodule

FILE: verif/tb_modular_arithmetic_unit.sv
// Self-checking testbench for modular_arithmetic_unit.
// A scoreboard class computes each residue from the op fields and the current modulus.
// Depends on mau_pkg and the RTL of the top level only.
`timescale 1ns / 100ps

module tb_modular_arithmetic_unit;

    localparam int ClkHalf = 4;
    localparam int SettleCycles = 300;
    localparam int TimeoutNs = 60_000_000;
    localparam logic [mau_pkg::ResBits-1:0] residue_max = 30'd1073741822;

    typedef bit [mau_pkg::ResBits-1:0] t_residue;

    typedef struct {
        mau_pkg::t_op op;
        t_residue operand_a;
        t_residue operand_b;
        bit [mau_pkg::ExpBits-1:0] exponent;
        bit [mau_pkg::RawBits-1:0] raw_integer;
    } t_mau_txn;

    // Residue predictor and queue of residues still owed by the block
    class residue_scoreboard;
        bit [63:0] modulus;
        t_residue pending_residues[$];
        int failures;

        function new();
            modulus = 64'(mau_pkg::ModReset);
            failures = 0;
        endfunction

        function void set_modulus(t_residue value);
            modulus = 64'(value);
        endfunction

        // Right-to-left square-and-multiply
        function bit [63:0] power_mod(bit [63:0] base, bit [mau_pkg::ExpBits-1:0] e);
            bit [63:0] acc;
            bit [63:0] sq;
            acc = 64'd1 % modulus;
            sq = base;
            for (int i = 0; i < mau_pkg::ExpBits; i++) begin
                if (e[i]) acc = (acc * sq) % modulus;
                sq = (sq * sq) % modulus;
            end
            return acc;
        endfunction

        // Fermat inverse; zero maps to zero
        function bit [63:0] inverse_mod(bit [63:0] a);
            if (a == 0) return 64'd0;
            return power_mod(a, mau_pkg::ExpBits'(modulus - 64'd2));
        endfunction

        function t_residue compute_residue(t_mau_txn txn);
            bit [63:0] a;
            bit [63:0] b;
            bit [63:0] rem;
            bit [63:0] r;
            if (modulus < 64'd2) return '0;
            a = 64'(txn.operand_a) % modulus;
            b = 64'(txn.operand_b) % modulus;
            case (txn.op)
                mau_pkg::OP_REDUCE: begin
                    // Wrap negative integers into 0 .. modulus-1
                    if (txn.raw_integer[mau_pkg::RawBits-1]) begin
                        rem = (64'd0 - txn.raw_integer) % modulus;
                        r = (rem != 0) ? modulus - rem : 64'd0;
                    end else begin
                        r = txn.raw_integer % modulus;
                    end
                end
                mau_pkg::OP_ADD:     r = (a + b) % modulus;
                mau_pkg::OP_SUB:     r = (a + modulus - b) % modulus;
                mau_pkg::OP_MUL:     r = (a * b) % modulus;
                mau_pkg::OP_DIV:     r = (b == 0) ? 64'd0 : (a * inverse_mod(b)) % modulus;
                mau_pkg::OP_POW:     r = power_mod(a, txn.exponent);
                mau_pkg::OP_INVERSE: r = inverse_mod(a);
                default:             r = (modulus - a) % modulus;
            endcase
            return t_residue'(r);
        endfunction

        function void note_operation(t_mau_txn txn);
            pending_residues.push_back(compute_residue(txn));
        endfunction

        function void check_residue(logic [mau_pkg::ResBits-1:0] actual);
            t_residue want;
            if (pending_residues.size() == 0) begin
                $error("result_value: unexpected result %0d, nothing outstanding", actual);
                failures++;
                return;
            end
            want = pending_residues.pop_front();
            if (actual !== want) begin
                $error("result_value: expected %0d, actual %0d", want, actual);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_residues.size();
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [mau_pkg::ResBits-1:0]        i_cfg_modulus = mau_pkg::ModReset;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic [2:0]                         i_op = '0;
    logic [mau_pkg::ResBits-1:0]        i_operand_a = '0;
    logic [mau_pkg::ResBits-1:0]        i_operand_b = '0;
    logic [mau_pkg::ExpBits-1:0]        i_exponent = '0;
    logic signed [mau_pkg::RawBits-1:0] i_raw_integer = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic [mau_pkg::ResBits-1:0]        o_result_value;

    residue_scoreboard sb;
    int stall_mode = 0;
    int stall_left = 0;

    modular_arithmetic_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_modulus  (i_cfg_modulus),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_exponent     (i_exponent),
        .i_raw_integer  (i_raw_integer),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value)
    );

    always begin
        #ClkHalf i_clk = 1'b1;
        #ClkHalf i_clk = 1'b0;
    end

    // Receiver stall: switch between free-running, random and mostly-stalled stretches
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(50, 400);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       i_out_stall = 1'b0;
            1:       i_out_stall = 1'($urandom_range(0, 1));
            default: i_out_stall = ($urandom_range(0, 7) != 0);
        endcase
    end

    // Check every result transaction against the oldest predicted residue
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_residue(o_result_value);
        end
    end

    function automatic t_mau_txn mk_operation(mau_pkg::t_op op, t_residue a, t_residue b,
                                              bit [mau_pkg::ExpBits-1:0] e,
                                              bit [mau_pkg::RawBits-1:0] raw);
        t_mau_txn txn;
        txn.op = op;
        txn.operand_a = a;
        txn.operand_b = b;
        txn.exponent = e;
        txn.raw_integer = raw;
        return txn;
    endfunction

    // Mostly reduced operands, with zero, modulus-1 and unreduced values mixed in
    function automatic t_residue pick_operand(bit [63:0] m);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return (m >= 2) ? t_residue'(m - 64'd1) : '0;
            2:       return t_residue'($urandom_range(0, residue_max));
            default: return (m >= 2) ? t_residue'($urandom_range(0, 32'(m - 64'd1)))
                                     : t_residue'($urandom_range(0, residue_max));
        endcase
    endfunction

    function automatic t_mau_txn random_operation();
        t_mau_txn txn;
        bit [63:0] m;
        bit [63:0] wide;
        m = sb.modulus;
        txn.op = mau_pkg::t_op'($urandom_range(0, 7));
        txn.operand_a = pick_operand(m);
        txn.operand_b = pick_operand(m);
        // Keep most exponents short; a few use the full width
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       txn.exponent = wide[mau_pkg::ExpBits-1:0];
            1:       txn.exponent = '0;
            default: txn.exponent = mau_pkg::ExpBits'(wide >> $urandom_range(44, 63));
        endcase
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       txn.raw_integer = 64'($signed(wide) >>> $urandom_range(32, 62));
            1:       txn.raw_integer = 64'(longint'(m) * (longint'($urandom_range(0, 2000)) - 1000));
            default: txn.raw_integer = wide;
        endcase
        return txn;
    endfunction

    task automatic send_operation(input t_mau_txn txn);
        @(negedge i_clk);
        i_op = txn.op;
        i_operand_a = txn.operand_a;
        i_operand_b = txn.operand_b;
        i_exponent = txn.exponent;
        i_raw_integer = txn.raw_integer;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_operation(txn);
    endtask

    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Stop sending and wait until every residue is back and the block has gone quiet
    task automatic drain();
        hold_off(1);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_modulus(input t_residue value);
        @(negedge i_clk);
        i_cfg_modulus = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_modulus(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Bursts of back-to-back transactions, some separated by short or long gaps
    task automatic run_random(input int count);
        int sent_here;
        int burst;
        sent_here = 0;
        while (sent_here < count) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && sent_here < count; k++) begin
                send_operation(random_operation());
                sent_here++;
            end
            case ($urandom_range(0, 5))
                0, 1:    ;
                2:       hold_off($urandom_range(20, 300));
                default: hold_off($urandom_range(1, 5));
            endcase
        end
    endtask

    initial begin
        bit [63:0] wide;
        sb = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes and special cases under the reset modulus
        wide = {$urandom, $urandom};
        send_operation(mk_operation(mau_pkg::OP_REDUCE, '0, '0, '0, 64'd0));
        send_operation(mk_operation(mau_pkg::OP_REDUCE, '0, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF));
        send_operation(mk_operation(mau_pkg::OP_REDUCE, '0, '0, '0, 64'h8000_0000_0000_0000));
        send_operation(mk_operation(mau_pkg::OP_REDUCE, '0, '0, '0, '1));
        send_operation(mk_operation(mau_pkg::OP_REDUCE, '0, '0, '0, 64'(-64'sd998244353)));
        send_operation(mk_operation(mau_pkg::OP_ADD, mau_pkg::ModReset - 30'd1,
                                    mau_pkg::ModReset - 30'd1, '0, '0));
        send_operation(mk_operation(mau_pkg::OP_ADD, '0, '0, '0, '0));
        send_operation(mk_operation(mau_pkg::OP_SUB, '0, mau_pkg::ModReset - 30'd1, '0, '0));
        send_operation(mk_operation(mau_pkg::OP_SUB, residue_max, 30'd5, '0, '0));
        send_operation(mk_operation(mau_pkg::OP_MUL, mau_pkg::ModReset - 30'd1,
                                    mau_pkg::ModReset - 30'd1, '0, '0));
        send_operation(mk_operation(mau_pkg::OP_MUL, residue_max, residue_max, '0, '0));
        send_operation(mk_operation(mau_pkg::OP_DIV, 30'd7, '0, '0, '0));
        send_operation(mk_operation(mau_pkg::OP_DIV, 30'd12345, 30'd678, '0, '0));
        send_operation(mk_operation(mau_pkg::OP_DIV, 30'd99, mau_pkg::ModReset, '0, '0));
        send_operation(mk_operation(mau_pkg::OP_POW, '0, '0, '0, '0));
        send_operation(mk_operation(mau_pkg::OP_POW, 30'd3, '0, '1, '0));
        send_operation(mk_operation(mau_pkg::OP_POW, mau_pkg::ModReset - 30'd1, '0, 63'd2, '0));
        send_operation(mk_operation(mau_pkg::OP_POW, 30'd123456789, '0,
                                    wide[mau_pkg::ExpBits-1:0], '1));
        send_operation(mk_operation(mau_pkg::OP_INVERSE, '0, '0, '0, '0));
        send_operation(mk_operation(mau_pkg::OP_INVERSE, 30'd1, '0, '0, '0));
        send_operation(mk_operation(mau_pkg::OP_INVERSE, mau_pkg::ModReset - 30'd1, '0, '0, '0));
        send_operation(mk_operation(mau_pkg::OP_NEGATE, '0, '0, '0, '0));
        send_operation(mk_operation(mau_pkg::OP_NEGATE, residue_max, '1, '1, '1));
        drain();

        // Random phases over several moduli, degenerate and composite ones included
        write_modulus(30'd1000000007);
        run_random(15);
        // Hold the sender until every result is back, then resume
        drain();
        run_random(15);
        drain();
        write_modulus(30'd1073741789);
        run_random(25);
        drain();
        write_modulus(30'd2);
        run_random(10);
        drain();
        write_modulus(30'd3);
        run_random(8);
        drain();
        write_modulus(30'd1073741823);
        run_random(12);
        drain();
        write_modulus(30'd1);
        run_random(4);
        drain();
        write_modulus(30'd0);
        run_random(4);
        drain();
        write_modulus(30'd65537);
        run_random(24);
        drain();

        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("modular_arithmetic_unit: match");
        end else begin
            $display("modular_arithmetic_unit: mismatch");
        end
        $finish;
    end

    // End the run if the block hangs
    initial begin
        #TimeoutNs;
        $display("modular_arithmetic_unit: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/mau_pkg.sv
design/mau_ctrl.sv
design/mau_datapath.sv
design/modular_arithmetic_unit.sv
verif/tb_modular_arithmetic_unit.sv
